[sv/sorted_key_table_core_defines.svh]
// Assertion macros for the sorted key table checker.
`ifndef SORTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sorted key table check failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sorted key table check failed: %m");

`endif

[sv/skt_pkg.sv]
// Types, codes and constants shared by the sorted key table modules.
package skt_pkg;

	localparam int KEY_W        = 32;
	localparam int CAPACITY_DEF = 16;
	localparam int COUNT_OUT_W  = 5;
	localparam int S_TDATA_W    = 32;
	localparam int M_TDATA_W    = 40;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_EV,
		ST_REM_CHK,
		ST_REM_EV,
		ST_SH_CHK,
		ST_SH_EV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ADDR_PREV,
		ADDR_SLOT,
		ADDR_NEXT,
		ADDR_HEAD
	} addr_sel_t;

	typedef enum logic [0:0] {
		WDATA_KEY,
		WDATA_RDATA
	} wdata_sel_t;

	typedef enum logic [2:0] {
		SLOT_HOLD,
		SLOT_COUNT,
		SLOT_ZERO,
		SLOT_INC,
		SLOT_DEC
	} slot_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		OK_HOLD,
		OK_SET,
		OK_CLR
	} ok_op_t;

	typedef struct packed {
		logic       load;
		slot_op_t   slot_op;
		logic       rd_en;
		addr_sel_t  rd_sel;
		logic       wr_en;
		wdata_sel_t wdata_sel;
		cnt_op_t    cnt_op;
		ok_op_t     ok_op;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		op_t  in_op;
		logic full;
		logic empty;
		logic slot_zero;
		logic slot_at_count;
		logic next_at_count;
		logic rd_ge_key;
		logic rd_eq_key;
		logic out_free;
	} status_t;

endpackage

[sv/skt_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module skt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last read word while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/skt_ctrl.sv]
// Sequencer for the sorted key table: scan, shift and respond.
module skt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  skt_pkg::status_t status,
	output skt_pkg::cmd_t    cmd
);

	skt_pkg::state_t state_q;
	skt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			skt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (status.in_op == skt_pkg::OP_INSERT) begin
						if (status.full) begin
							cmd.ok_op = skt_pkg::OK_CLR;
							state_d   = skt_pkg::ST_FIN;
						end else begin
							cmd.slot_op = skt_pkg::SLOT_COUNT;
							state_d     = skt_pkg::ST_INS_CHK;
						end
					end else begin
						cmd.slot_op = skt_pkg::SLOT_ZERO;
						state_d     = skt_pkg::ST_REM_CHK;
					end
				end
			end
			skt_pkg::ST_INS_CHK: begin
				if (status.slot_zero) begin
					cmd.wr_en     = 1'b1;
					cmd.wdata_sel = skt_pkg::WDATA_KEY;
					cmd.cnt_op    = skt_pkg::CNT_INC;
					cmd.ok_op     = skt_pkg::OK_SET;
					state_d       = skt_pkg::ST_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = skt_pkg::ADDR_PREV;
					state_d    = skt_pkg::ST_INS_EV;
				end
			end
			skt_pkg::ST_INS_EV: begin
				cmd.wr_en = 1'b1;
				if (status.rd_ge_key) begin
					cmd.wdata_sel = skt_pkg::WDATA_RDATA;
					cmd.slot_op   = skt_pkg::SLOT_DEC;
					state_d       = skt_pkg::ST_INS_CHK;
				end else begin
					cmd.wdata_sel = skt_pkg::WDATA_KEY;
					cmd.cnt_op    = skt_pkg::CNT_INC;
					cmd.ok_op     = skt_pkg::OK_SET;
					state_d       = skt_pkg::ST_FIN;
				end
			end
			skt_pkg::ST_REM_CHK: begin
				if (status.slot_at_count) begin
					cmd.ok_op = skt_pkg::OK_CLR;
					state_d   = skt_pkg::ST_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = skt_pkg::ADDR_SLOT;
					state_d    = skt_pkg::ST_REM_EV;
				end
			end
			skt_pkg::ST_REM_EV: begin
				if (!status.rd_ge_key) begin
					cmd.slot_op = skt_pkg::SLOT_INC;
					state_d     = skt_pkg::ST_REM_CHK;
				end else if (status.rd_eq_key) begin
					state_d = skt_pkg::ST_SH_CHK;
				end else begin
					cmd.ok_op = skt_pkg::OK_CLR;
					state_d   = skt_pkg::ST_FIN;
				end
			end
			skt_pkg::ST_SH_CHK: begin
				if (status.next_at_count) begin
					cmd.cnt_op = skt_pkg::CNT_DEC;
					cmd.ok_op  = skt_pkg::OK_SET;
					state_d    = skt_pkg::ST_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = skt_pkg::ADDR_NEXT;
					state_d    = skt_pkg::ST_SH_EV;
				end
			end
			skt_pkg::ST_SH_EV: begin
				cmd.wr_en     = 1'b1;
				cmd.wdata_sel = skt_pkg::WDATA_RDATA;
				cmd.slot_op   = skt_pkg::SLOT_INC;
				state_d       = skt_pkg::ST_SH_CHK;
			end
			skt_pkg::ST_FIN: begin
				// fetch the head entry for the smallest key
				if (!status.empty) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = skt_pkg::ADDR_HEAD;
				end
				state_d = skt_pkg::ST_DONE;
			end
			skt_pkg::ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = skt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/skt_datapath.sv]
// Key store, scan slot, count and output register of the sorted key table.
module skt_datapath #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [skt_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skt_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	input  skt_pkg::cmd_t                 cmd,
	output skt_pkg::status_t              status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PAD_W = skt_pkg::M_TDATA_W - skt_pkg::COUNT_OUT_W - skt_pkg::KEY_W;

	logic signed [skt_pkg::KEY_W-1:0]       key_q;
	logic [CW-1:0]                          slot_q;
	logic [CW-1:0]                          count_q;
	logic                                   ok_q;
	logic                                   out_valid_q;
	logic                                   out_ok_q;
	logic [skt_pkg::COUNT_OUT_W-1:0]        out_count_q;
	logic [skt_pkg::KEY_W-1:0]              out_min_q;

	logic [CW-1:0]                          rd_slot;
	logic [CW:0]                            slot_next;
	logic [CW+skt_pkg::COUNT_OUT_W-1:0]     count_ext;
	logic [skt_pkg::KEY_W-1:0]              rdata;
	logic [skt_pkg::KEY_W-1:0]              wdata;

	always_comb begin
		case (cmd.rd_sel)
			skt_pkg::ADDR_PREV: rd_slot = slot_q - CW'(1);
			skt_pkg::ADDR_SLOT: rd_slot = slot_q;
			skt_pkg::ADDR_NEXT: rd_slot = slot_q + CW'(1);
			skt_pkg::ADDR_HEAD: rd_slot = '0;
			default:            rd_slot = '0;
		endcase
	end

	assign wdata = (cmd.wdata_sel == skt_pkg::WDATA_KEY) ? key_q : rdata;

	skt_ram #(
		.WIDTH (skt_pkg::KEY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (slot_q[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (rd_slot[AW-1:0]),
		.rdata (rdata)
	);

	assign slot_next = {1'b0, slot_q} + (CW+1)'(1);
	assign count_ext = {{skt_pkg::COUNT_OUT_W{1'b0}}, count_q};

	assign status.in_op         = skt_pkg::op_t'(s_tuser);
	assign status.full          = (count_q == CW'(CAPACITY));
	assign status.empty         = (count_q == '0);
	assign status.slot_zero     = (slot_q == '0);
	assign status.slot_at_count = (slot_q == count_q);
	assign status.next_at_count = (slot_next >= {1'b0, count_q});
	assign status.rd_ge_key     = ($signed(rdata) >= key_q);
	assign status.rd_eq_key     = (rdata == key_q);
	assign status.out_free      = !out_valid_q || m_tready;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= s_tdata[skt_pkg::KEY_W-1:0];
		end
		case (cmd.slot_op)
			skt_pkg::SLOT_COUNT: slot_q <= count_q;
			skt_pkg::SLOT_ZERO:  slot_q <= '0;
			skt_pkg::SLOT_INC:   slot_q <= slot_q + CW'(1);
			skt_pkg::SLOT_DEC:   slot_q <= slot_q - CW'(1);
			default:             slot_q <= slot_q;
		endcase
		case (cmd.ok_op)
			skt_pkg::OK_SET: ok_q <= 1'b1;
			skt_pkg::OK_CLR: ok_q <= 1'b0;
			default:         ok_q <= ok_q;
		endcase
		if (cmd.out_load) begin
			out_ok_q    <= ok_q;
			out_count_q <= count_ext[skt_pkg::COUNT_OUT_W-1:0];
			out_min_q   <= status.empty ? '0 : rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				skt_pkg::CNT_INC: count_q <= count_q + CW'(1);
				skt_pkg::CNT_DEC: count_q <= count_q - CW'(1);
				default:          count_q <= count_q;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_min_q, out_count_q};

endmodule

[sv/sorted_key_table_core.sv]
// Top level of the sorted key table: sequencer plus key store datapath.
//
// Keeps up to CAPACITY signed 32-bit keys in ascending order in a RAM,
// duplicates allowed. Each input beat on the s_ channel carries one
// operation: s_tuser selects insert (0) or remove (1), s_tdata the key.
// An insert goes in front of the first stored key greater or equal and
// fails on a full table; a remove deletes one equal key or fails.
// Each operation yields exactly one m_ beat: m_tuser is the ok flag,
// m_tdata the count after the operation and the smallest stored key
// (zero when empty).
// One operation is worked on at a time. The key RAM has one read and one
// write port with a registered read, and the scan visits one entry per
// pass through a check state and an evaluate state. Reset clears the count
// and the output valid flag; the RAM contents need no clearing, so the
// block is ready to take a beat in the idle state that it enters at reset.
// The output register lets the next operation be accepted and worked on
// while a result still waits; if the receiver stalls, the finished
// operation holds in its last state until the result register frees.
module sorted_key_table_core #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skt_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] key
	input  logic                          s_tuser,  // [0] operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skt_pkg::M_TDATA_W-1:0] m_tdata,  // [4:0] entry_count, [36:5] smallest_key
	output logic                          m_tuser   // [0] ok
);

	skt_pkg::cmd_t    cmd;
	skt_pkg::status_t status;

	// sequencer: decide the next scan or shift step from the datapath status
	skt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: key RAM, scan slot, count and result register
	skt_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

[sv/skt_checker.sv]
// Port-level checks for the sorted key table, bound to the top level.
`include "sorted_key_table_core_defines.svh"

module skt_checker #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [skt_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	logic [skt_pkg::COUNT_OUT_W-1:0] last_count_q;

	// track the count reported by the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_count_q <= m_tdata[skt_pkg::COUNT_OUT_W-1:0];
		end
	end

	// one operation at a time: no beat is taken right after an accepted one
	`SKT_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// a stalled result holds
	`SKT_ASSERT_NXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// the count moves exactly when the operation succeeds
	`SKT_ASSERT_IMP(a_ok_moves_count, clk, arst_n, m_tvalid, (m_tuser && (m_tdata[4:0] != last_count_q)) || (!m_tuser && (m_tdata[4:0] == last_count_q)))

	// an empty table reports a zero smallest key
	`SKT_ASSERT_IMP(a_empty_zero, clk, arst_n, m_tvalid && (CAPACITY < 32) && (m_tdata[4:0] == '0), m_tdata[36:5] == '0)

endmodule

bind sorted_key_table_core skt_checker #(
	.CAPACITY (CAPACITY)
) u_skt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[verif/tb.sv]
// Testbench for sorted_key_table_core: stream driver, result monitor and a sorted-queue predictor.
`timescale 1ns / 100ps

module tb;
	import skt_pkg::*;

	localparam int TABLE_DEPTH  = CAPACITY_DEF;
	localparam int RANDOM_OPS   = 1900;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int IDLE_PERCENT = 18;
	localparam int QUIET_FROM   = 15000;
	localparam int QUIET_TO     = 22000;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] key;
	} table_request_t;

	typedef struct packed {
		logic               ok;
		logic [4:0]         count;
		logic signed [31:0] smallest;
	} table_reply_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tuser;

	table_request_t     pending_requests[$];
	table_reply_t       pending_replies[$];
	logic signed [31:0] stored_keys[$];
	logic signed [31:0] key_pool[6];
	int                 error_count = 0;
	int                 cycle_count = 0;
	int                 quiet_cycles = 0;

	sorted_key_table_core #(
		.CAPACITY(TABLE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("tb: mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// Keep the table as a sorted queue; an insert lands before all equal keys.
	function automatic table_reply_t apply_table_op(input op_t op, input logic signed [31:0] key);
		table_reply_t reply;
		int           pos;
		pos = 0;
		while (pos < stored_keys.size() && stored_keys[pos] < key)
			pos++;
		reply.ok = 1'b0;
		if (op == OP_INSERT) begin
			if (stored_keys.size() < TABLE_DEPTH) begin
				stored_keys.insert(pos, key);
				reply.ok = 1'b1;
			end
		end else if (pos < stored_keys.size() && stored_keys[pos] == key) begin
			stored_keys.delete(pos);
			reply.ok = 1'b1;
		end
		reply.count    = 5'(stored_keys.size());
		reply.smallest = (stored_keys.size() > 0) ? stored_keys[0] : 32'sd0;
		return reply;
	endfunction

	function automatic bit take_break();
		if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PERCENT;
	endfunction

	function automatic logic signed [31:0] pick_pool_key();
		int sel;
		sel = $urandom_range(0, 3);
		case (sel)
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $signed($urandom_range(0, 20)) - 32'sd10;
		endcase
	endfunction

	// Driver: present the next queued operation, predict each accepted beat.
	always @(posedge clk or negedge arst_n) begin : driver
		table_request_t next_req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				pending_replies.push_back(apply_table_op(op_t'(s_tuser), s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() > 0 && !take_break()) begin
					next_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_req.key;
					s_tuser  <= next_req.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each result beat with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		table_reply_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !take_break();
			if (m_tvalid && m_tready) begin
				if (pending_replies.size() == 0) begin
					report_mismatch($sformatf("result with none expected, m_tdata=%h", m_tdata));
				end else begin
					want = pending_replies.pop_front();
					if (m_tuser !== want.ok)
						report_mismatch($sformatf("ok %b, expected %b", m_tuser, want.ok));
					if (m_tdata[4:0] !== want.count)
						report_mismatch($sformatf("entry_count %0d, expected %0d",
							m_tdata[4:0], want.count));
					if (m_tdata[36:5] !== want.smallest)
						report_mismatch($sformatf("smallest_key %0d, expected %0d",
							$signed(m_tdata[36:5]), want.smallest));
					if (m_tdata[M_TDATA_W-1:37] !== '0)
						report_mismatch($sformatf("padding bits %b not zero",
							m_tdata[M_TDATA_W-1:37]));
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	task automatic queue_op(input op_t op, input logic signed [31:0] key);
		table_request_t req;
		req.op  = op;
		req.key = key;
		pending_requests.push_back(req);
	endtask

	initial begin : stimulus
		int   burst_len;
		int   insert_pct;
		int   issued;
		op_t  op;
		logic signed [31:0] key;

		// Directed: empty table, extremes, duplicates, absent key, sole element.
		queue_op(OP_REMOVE, 32'sd5);
		queue_op(OP_INSERT, 32'sh7FFF_FFFF);
		queue_op(OP_INSERT, 32'sh8000_0000);
		queue_op(OP_INSERT, 32'sd0);
		queue_op(OP_INSERT, -32'sd1);
		queue_op(OP_INSERT, 32'sd0);
		queue_op(OP_REMOVE, 32'sd1);
		queue_op(OP_REMOVE, 32'sd0);
		queue_op(OP_REMOVE, 32'sh8000_0000);
		queue_op(OP_REMOVE, 32'sh7FFF_FFFF);
		queue_op(OP_REMOVE, -32'sd1);
		queue_op(OP_REMOVE, 32'sd0);
		queue_op(OP_REMOVE, 32'sd0);
		queue_op(OP_INSERT, 32'sh5555_AAAA);
		queue_op(OP_INSERT, 32'shAAAA_5555);

		// Random: bursts leaning to fill, drain or neither, keys mostly from a slowly changing pool.
		foreach (key_pool[i])
			key_pool[i] = pick_pool_key();
		issued = 0;
		while (issued < RANDOM_OPS) begin
			burst_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: insert_pct = 80;
				1: insert_pct = 20;
				default: insert_pct = 50;
			endcase
			key_pool[$urandom_range(0, 5)] = pick_pool_key();
			key_pool[$urandom_range(0, 5)] = pick_pool_key();
			for (int n = 0; n < burst_len && issued < RANDOM_OPS; n++) begin
				op  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
				if ($urandom_range(0, 99) < ((op == OP_REMOVE) ? 85 : 70))
					key = key_pool[$urandom_range(0, 5)];
				else
					key = $urandom;
				queue_op(op, key);
				issued++;
			end
		end

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_requests.size() > 0 || s_tvalid || pending_replies.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
